[src/u8vsd_pkg.sv]
// ----------------------------------------------------------------------------
// u8vsd_pkg
// Shared types, codes and constants of the strict UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8vsd_pkg;

   // field widths
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned CP_W       = 21;
   localparam int unsigned KIND_W     = 2;
   localparam int unsigned ERR_W      = 3;
   localparam int unsigned CNT_W      = 2;
   localparam int unsigned LEN_W      = 3;
   localparam int unsigned HELD_DEPTH = 3;

   // input operation codes
   typedef enum logic [0:0] {
      OP_DATA = 1'b0,
      OP_END  = 1'b1
   } op_type;

   // result kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_NONE = 2'd0,
      KIND_CHAR = 2'd1,
      KIND_EOL  = 2'd2
   } kind_type;

   // error codes
   typedef enum logic [ERR_W-1:0] {
      ERR_OK        = 3'd0,
      ERR_MALFORMED = 3'd1,
      ERR_TRUNCATED = 3'd2,
      ERR_FINISHED  = 3'd3,
      ERR_FAILED    = 3'd4
   } error_type;

   // lead byte ranges
   localparam logic [BYTE_W-1:0] ASCII_MAX = 8'h7f;
   localparam logic [BYTE_W-1:0] LEAD2_MIN = 8'hc2;
   localparam logic [BYTE_W-1:0] LEAD2_MAX = 8'hdf;
   localparam logic [BYTE_W-1:0] LEAD3_MIN = 8'he0;
   localparam logic [BYTE_W-1:0] LEAD3_MAX = 8'hef;
   localparam logic [BYTE_W-1:0] LEAD4_MIN = 8'hf0;
   localparam logic [BYTE_W-1:0] LEAD4_MAX = 8'hf4;
   localparam logic [BYTE_W-1:0] LEAD_SURR = 8'hed;

   // second byte limits against overlong forms and surrogates
   localparam logic [BYTE_W-1:0] E0_SEC_MIN = 8'ha0;
   localparam logic [BYTE_W-1:0] ED_SEC_MAX = 8'h9f;
   localparam logic [BYTE_W-1:0] F0_SEC_MIN = 8'h90;
   localparam logic [BYTE_W-1:0] F4_SEC_MAX = 8'h8f;

   // continuation byte marker in the top two bits
   localparam logic [1:0] CONT_TAG = 2'b10;

   // special code points
   localparam logic [CP_W-1:0] CP_BOM = 21'h00feff;
   localparam logic [CP_W-1:0] CP_CR  = 21'h00000d;
   localparam logic [CP_W-1:0] CP_LF  = 21'h00000a;

   // decoder state carried from beat to beat
   typedef struct packed {
      logic [CNT_W-1:0] held_count;
      logic             first_char_pending;
      logic             last_was_cr;
      logic             finished;
      logic             failed;
   } dec_state_type;

   // one result beat
   typedef struct packed {
      kind_type         kind;
      logic [CP_W-1:0]  code_point;
      error_type        error_code;
      logic [CNT_W-1:0] pending_count;
   } result_type;

   // sequence length from the lead byte, zero for a bad lead
   function automatic logic [LEN_W-1:0] seq_length(input logic [BYTE_W-1:0] lead);
      logic [LEN_W-1:0] len;
      len = 3'd0;
      if (lead <= ASCII_MAX) begin
         len = 3'd1;
      end else if (lead >= LEAD2_MIN && lead <= LEAD2_MAX) begin
         len = 3'd2;
      end else if (lead >= LEAD3_MIN && lead <= LEAD3_MAX) begin
         len = 3'd3;
      end else if (lead >= LEAD4_MIN && lead <= LEAD4_MAX) begin
         len = 3'd4;
      end
      return len;
   endfunction

endpackage

[src/utf8_validating_stream_decoder_core.sv]
// ----------------------------------------------------------------------------
// utf8_validating_stream_decoder_core
// Strict UTF-8 stream decoder with line-end detection and sticky errors.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_ready  | req_op, req_byte_in
//   rsp     | out       | rsp_valid / rsp_ready  | rsp_kind, rsp_code_point,
//           |           |                        | rsp_error_code, rsp_pending_count
//
// One result beat for every request beat, one beat per cycle sustained while rsp_ready holds.
// A beat passes the input register, then the decode step into the
// result register; the decoder state loop closes in that single step.
// Reset clears the held count and the flags but sets first_char_pending; the held bytes need no reset.
// A stalled result holds the result register; the input register still
// takes a beat while it is empty, and req_ready drops once it too is full.
// ----------------------------------------------------------------------------
module utf8_validating_stream_decoder_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_op,
   input  logic [u8vsd_pkg::BYTE_W-1:0]        req_byte_in,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [u8vsd_pkg::KIND_W-1:0]        rsp_kind,
   output logic [u8vsd_pkg::CP_W-1:0]          rsp_code_point,
   output logic [u8vsd_pkg::ERR_W-1:0]         rsp_error_code,
   output logic [u8vsd_pkg::CNT_W-1:0]         rsp_pending_count
);

   logic                          in_valid_ff, in_valid_in;
   logic                          in_op_ff;
   logic [u8vsd_pkg::BYTE_W-1:0]  in_byte_ff;
   logic                          out_valid_ff, out_valid_in;
   u8vsd_pkg::result_type         out_ff;
   u8vsd_pkg::dec_state_type      state_ff, state_in;
   logic [u8vsd_pkg::BYTE_W-1:0]  held_ff [u8vsd_pkg::HELD_DEPTH];
   u8vsd_pkg::result_type         step_result;
   logic                          hold_we;
   logic                          out_free;
   logic                          step_go;
   logic                          req_take;

   // handshake control
   always_comb begin
      out_free     = !out_valid_ff || rsp_ready;
      step_go      = in_valid_ff && out_free;
      req_ready    = !in_valid_ff || step_go;
      req_take     = req_valid && req_ready;
      in_valid_in  = req_take || (in_valid_ff && !step_go);
      out_valid_in = step_go || (out_valid_ff && !rsp_ready);
   end

   // decode step
   u8vsd_decode u_decode (
      .state      (state_ff),
      .held       (held_ff),
      .op         (in_op_ff),
      .byte_in    (in_byte_ff),
      .state_next (state_in),
      .hold_we    (hold_we),
      .result     (step_result)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff                 <= 1'b0;
         out_valid_ff                <= 1'b0;
         state_ff.held_count         <= '0;
         state_ff.first_char_pending <= 1'b1;
         state_ff.last_was_cr        <= 1'b0;
         state_ff.finished           <= 1'b0;
         state_ff.failed             <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (step_go) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff   <= req_op;
         in_byte_ff <= req_byte_in;
      end
      if (step_go) begin
         out_ff <= step_result;
      end
      if (step_go && hold_we) begin
         case (state_ff.held_count)
            2'd0:    held_ff[0] <= in_byte_ff;
            2'd1:    held_ff[1] <= in_byte_ff;
            2'd2:    held_ff[2] <= in_byte_ff;
            default: ;
         endcase
      end
   end

   // result beat
   assign rsp_valid         = out_valid_ff;
   assign rsp_kind          = out_ff.kind;
   assign rsp_code_point    = out_ff.code_point;
   assign rsp_error_code    = out_ff.error_code;
   assign rsp_pending_count = out_ff.pending_count;

   // an error beat carries no character
   a_error_no_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != u8vsd_pkg::ERR_OK |->
         rsp_kind == u8vsd_pkg::KIND_NONE && rsp_code_point == '0)
      else $error("error beat carries a character");

   // pending count only reported with truncation
   a_pending_trunc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pending_count != '0 |->
         rsp_error_code == u8vsd_pkg::ERR_TRUNCATED)
      else $error("pending count without truncation");

   // end of stream is sticky
   a_finish_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff.finished |=> state_ff.finished)
      else $error("finished flag cleared");

   // both stages full and output stalled must stop the input side
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_ready |-> !req_ready)
      else $error("input taken while both stages are stalled");

endmodule

[src/u8vsd_decode.sv]
// ----------------------------------------------------------------------------
// u8vsd_decode
// Per-beat decode step: judges the byte against the held bytes and flags,
// builds the result and the next state.
// ----------------------------------------------------------------------------
module u8vsd_decode (
   input  u8vsd_pkg::dec_state_type      state,
   input  logic [u8vsd_pkg::BYTE_W-1:0]  held [u8vsd_pkg::HELD_DEPTH],
   input  logic                          op,
   input  logic [u8vsd_pkg::BYTE_W-1:0]  byte_in,
   output u8vsd_pkg::dec_state_type      state_next,
   output logic                          hold_we,
   output u8vsd_pkg::result_type         result
);

   logic [u8vsd_pkg::BYTE_W-1:0] lead;
   logic [u8vsd_pkg::BYTE_W-1:0] seq1;
   logic [u8vsd_pkg::BYTE_W-1:0] seq2;
   logic [u8vsd_pkg::BYTE_W-1:0] seq3;
   logic [u8vsd_pkg::LEN_W-1:0]  need;
   logic [u8vsd_pkg::LEN_W-1:0]  have;
   logic                         cont_ok;
   logic                         range_ok;
   logic [u8vsd_pkg::CP_W-1:0]   cp;

   // assemble the sequence: the newest byte is always the last one
   always_comb begin
      lead = (state.held_count != '0) ? held[0] : byte_in;
      need = u8vsd_pkg::seq_length(lead);
      have = {1'b0, state.held_count} + 3'd1;
      seq1 = (need == 3'd2) ? byte_in : held[1];
      seq2 = (need == 3'd3) ? byte_in : held[2];
      seq3 = byte_in;
   end

   // continuation, overlong and surrogate checks
   always_comb begin
      cont_ok = (need < 3'd2 || seq1[7:6] == u8vsd_pkg::CONT_TAG) &&
                (need < 3'd3 || seq2[7:6] == u8vsd_pkg::CONT_TAG) &&
                (need < 3'd4 || seq3[7:6] == u8vsd_pkg::CONT_TAG);
      range_ok = !((lead == u8vsd_pkg::LEAD3_MIN && seq1 < u8vsd_pkg::E0_SEC_MIN) ||
                   (lead == u8vsd_pkg::LEAD_SURR && seq1 > u8vsd_pkg::ED_SEC_MAX) ||
                   (lead == u8vsd_pkg::LEAD4_MIN && seq1 < u8vsd_pkg::F0_SEC_MIN) ||
                   (lead == u8vsd_pkg::LEAD4_MAX && seq1 > u8vsd_pkg::F4_SEC_MAX));
   end

   // code point from the payload bits of each byte
   always_comb begin
      case (need)
         3'd1:    cp = {13'd0, lead};
         3'd2:    cp = {10'd0, lead[4:0], seq1[5:0]};
         3'd3:    cp = {5'd0, lead[3:0], seq1[5:0], seq2[5:0]};
         3'd4:    cp = {lead[2:0], seq1[5:0], seq2[5:0], seq3[5:0]};
         default: cp = '0;
      endcase
   end

   // sticky flags, sequence collection and line-end handling
   always_comb begin
      state_next           = state;
      hold_we              = 1'b0;
      result.kind          = u8vsd_pkg::KIND_NONE;
      result.code_point    = '0;
      result.error_code    = u8vsd_pkg::ERR_OK;
      result.pending_count = '0;
      if (state.finished) begin
         state_next.failed = 1'b1;
         result.error_code = u8vsd_pkg::ERR_FINISHED;
      end else if (state.failed) begin
         result.error_code = u8vsd_pkg::ERR_FAILED;
      end else if (op == u8vsd_pkg::OP_END) begin
         if (state.held_count != '0) begin
            result.pending_count = state.held_count;
            result.error_code    = u8vsd_pkg::ERR_TRUNCATED;
            state_next.failed    = 1'b1;
         end else begin
            state_next.finished = 1'b1;
         end
      end else if (need == '0) begin
         result.error_code = u8vsd_pkg::ERR_MALFORMED;
         state_next.failed = 1'b1;
      end else if (have < need) begin
         hold_we               = 1'b1;
         state_next.held_count = state.held_count + 2'd1;
      end else begin
         state_next.held_count = '0;
         if (!(cont_ok && range_ok)) begin
            result.error_code = u8vsd_pkg::ERR_MALFORMED;
            state_next.failed = 1'b1;
         end else begin
            state_next.first_char_pending = 1'b0;
            if (state.first_char_pending && cp == u8vsd_pkg::CP_BOM) begin
               // leading byte-order mark is dropped
            end else if (cp == u8vsd_pkg::CP_CR) begin
               state_next.last_was_cr = 1'b1;
               result.kind            = u8vsd_pkg::KIND_EOL;
            end else if (cp == u8vsd_pkg::CP_LF) begin
               // lf straight after cr belongs to the same line end
               if (state.last_was_cr) begin
                  state_next.last_was_cr = 1'b0;
               end else begin
                  result.kind = u8vsd_pkg::KIND_EOL;
               end
            end else begin
               state_next.last_was_cr = 1'b0;
               result.kind            = u8vsd_pkg::KIND_CHAR;
               result.code_point      = cp;
            end
         end
      end
   end

endmodule

[tb/utf8_validating_stream_decoder_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_validating_stream_decoder_core_test
// Self-checking bench for the strict UTF-8 stream decoder.
//
// A queue of stream beats is built up front: a directed opening with the BOM,
// the scalar boundaries and the line-end cases, then a long run of random
// well-formed characters, then one way of closing the stream (clean end, bad
// lead, bad continuation, overlong or surrogate form, truncation), then noise
// that hits the sticky finished and failed states. A clocked driver offers
// the beats and a local decoder predicts each result; a clocked monitor
// compares every result beat field by field. Both sides idle at random in
// the first two of three phases, and once the receiver holds off long enough
// to back up the block.
// ----------------------------------------------------------------------------
module utf8_validating_stream_decoder_core_test;

   typedef logic [u8vsd_pkg::BYTE_W-1:0] byte_type;
   typedef logic [u8vsd_pkg::CP_W-1:0]   cp_type;

   typedef struct packed {
      u8vsd_pkg::op_type op;
      byte_type          data;
   } stream_beat_type;

   // scalar values at the edges of each encoding length and of the surrogate gap, and the BOM
   localparam cp_type BOUNDARY_CPS [11] = '{
      21'h000000, 21'h00007f, 21'h000080, 21'h0007ff, 21'h000800, 21'h00d7ff,
      21'h00e000, 21'h00feff, 21'h00ffff, 21'h010000, 21'h10ffff
   };

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic                                req_op = 1'b0;
   logic [u8vsd_pkg::BYTE_W-1:0]        req_byte_in = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic [u8vsd_pkg::KIND_W-1:0]        rsp_kind;
   logic [u8vsd_pkg::CP_W-1:0]          rsp_code_point;
   logic [u8vsd_pkg::ERR_W-1:0]         rsp_error_code;
   logic [u8vsd_pkg::CNT_W-1:0]         rsp_pending_count;

   stream_beat_type       byte_stream_q [$];
   u8vsd_pkg::result_type predicted_q [$];
   int                    stream_len = 0;
   int                    beats_sent = 0;
   int                    beats_checked = 0;
   int                    mismatch_count = 0;
   int                    hold_left = 0;
   bit                    hold_done = 1'b0;
   string                 close_reason;

   // local copy of the decoder state
   byte_type                    dec_held [u8vsd_pkg::HELD_DEPTH];
   logic [u8vsd_pkg::CNT_W-1:0] dec_count = '0;
   logic                        dec_bom_armed = 1'b1;
   logic                        dec_after_cr = 1'b0;
   logic                        dec_ended = 1'b0;
   logic                        dec_broken = 1'b0;

   utf8_validating_stream_decoder_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_byte_in       (req_byte_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_code_point    (rsp_code_point),
      .rsp_error_code    (rsp_error_code),
      .rsp_pending_count (rsp_pending_count)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // advance the local decoder by one beat and return the result it gives
   function automatic u8vsd_pkg::result_type decode_beat(input u8vsd_pkg::op_type op,
                                                         input byte_type b);
      u8vsd_pkg::result_type r;
      byte_type              seq [4];
      byte_type              lead;
      cp_type                cp;
      int unsigned           need;
      logic                  ok;
      logic                  bom_drop;
      r.kind          = u8vsd_pkg::KIND_NONE;
      r.code_point    = '0;
      r.error_code    = u8vsd_pkg::ERR_OK;
      r.pending_count = '0;
      if (dec_ended) begin
         dec_broken   = 1'b1;
         r.error_code = u8vsd_pkg::ERR_FINISHED;
      end else if (dec_broken) begin
         r.error_code = u8vsd_pkg::ERR_FAILED;
      end else if (op == u8vsd_pkg::OP_END) begin
         if (dec_count != 0) begin
            r.pending_count = dec_count;
            r.error_code    = u8vsd_pkg::ERR_TRUNCATED;
            dec_broken      = 1'b1;
         end else begin
            dec_ended = 1'b1;
         end
      end else begin
         lead = (dec_count != 0) ? dec_held[0] : b;
         if (lead <= u8vsd_pkg::ASCII_MAX) need = 1;
         else if (lead >= u8vsd_pkg::LEAD2_MIN && lead <= u8vsd_pkg::LEAD2_MAX) need = 2;
         else if (lead >= u8vsd_pkg::LEAD3_MIN && lead <= u8vsd_pkg::LEAD3_MAX) need = 3;
         else if (lead >= u8vsd_pkg::LEAD4_MIN && lead <= u8vsd_pkg::LEAD4_MAX) need = 4;
         else need = 0;
         if (need == 0) begin
            r.error_code = u8vsd_pkg::ERR_MALFORMED;
            dec_broken   = 1'b1;
         end else if (dec_count + 1 < need) begin
            // still collecting the sequence
            dec_held[dec_count] = b;
            dec_count           = dec_count + 1'b1;
         end else begin
            for (int i = 0; i < dec_count; i++) seq[i] = dec_held[i];
            seq[dec_count] = b;
            dec_count      = '0;
            ok = 1'b1;
            for (int i = 1; i < need; i++) begin
               if (seq[i][7:6] != u8vsd_pkg::CONT_TAG) ok = 1'b0;
            end
            // overlong and surrogate limits on the second byte
            if ((lead == u8vsd_pkg::LEAD3_MIN && seq[1] < u8vsd_pkg::E0_SEC_MIN) ||
                (lead == u8vsd_pkg::LEAD_SURR && seq[1] > u8vsd_pkg::ED_SEC_MAX) ||
                (lead == u8vsd_pkg::LEAD4_MIN && seq[1] < u8vsd_pkg::F0_SEC_MIN) ||
                (lead == u8vsd_pkg::LEAD4_MAX && seq[1] > u8vsd_pkg::F4_SEC_MAX)) ok = 1'b0;
            if (!ok) begin
               r.error_code = u8vsd_pkg::ERR_MALFORMED;
               dec_broken   = 1'b1;
            end else begin
               case (need)
                  1: cp = {13'd0, seq[0]};
                  2: cp = {10'd0, seq[0][4:0], seq[1][5:0]};
                  3: cp = {5'd0, seq[0][3:0], seq[1][5:0], seq[2][5:0]};
                  default: cp = {seq[0][2:0], seq[1][5:0], seq[2][5:0], seq[3][5:0]};
               endcase
               bom_drop      = dec_bom_armed && cp == u8vsd_pkg::CP_BOM;
               dec_bom_armed = 1'b0;
               if (bom_drop) begin
                  // leading byte-order mark is dropped
               end else if (cp == u8vsd_pkg::CP_CR) begin
                  dec_after_cr = 1'b1;
                  r.kind       = u8vsd_pkg::KIND_EOL;
               end else if (cp == u8vsd_pkg::CP_LF) begin
                  if (dec_after_cr) dec_after_cr = 1'b0;
                  else r.kind = u8vsd_pkg::KIND_EOL;
               end else begin
                  dec_after_cr = 1'b0;
                  r.kind       = u8vsd_pkg::KIND_CHAR;
                  r.code_point = cp;
               end
            end
         end
      end
      return r;
   endfunction

   task automatic push_beat(input u8vsd_pkg::op_type op, input byte_type data);
      stream_beat_type s;
      s.op   = op;
      s.data = data;
      byte_stream_q.push_back(s);
   endtask

   // encode one scalar value as UTF-8 beats
   task automatic put_char(input cp_type cp);
      if (cp < 21'h80) begin
         push_beat(u8vsd_pkg::OP_DATA, cp[7:0]);
      end else if (cp < 21'h800) begin
         push_beat(u8vsd_pkg::OP_DATA, {3'b110, cp[10:6]});
         push_beat(u8vsd_pkg::OP_DATA, {u8vsd_pkg::CONT_TAG, cp[5:0]});
      end else if (cp < 21'h10000) begin
         push_beat(u8vsd_pkg::OP_DATA, {4'b1110, cp[15:12]});
         push_beat(u8vsd_pkg::OP_DATA, {u8vsd_pkg::CONT_TAG, cp[11:6]});
         push_beat(u8vsd_pkg::OP_DATA, {u8vsd_pkg::CONT_TAG, cp[5:0]});
      end else begin
         push_beat(u8vsd_pkg::OP_DATA, {5'b11110, cp[20:18]});
         push_beat(u8vsd_pkg::OP_DATA, {u8vsd_pkg::CONT_TAG, cp[17:12]});
         push_beat(u8vsd_pkg::OP_DATA, {u8vsd_pkg::CONT_TAG, cp[11:6]});
         push_beat(u8vsd_pkg::OP_DATA, {u8vsd_pkg::CONT_TAG, cp[5:0]});
      end
   endtask

   function automatic byte_type rand_byte(input int unsigned lo, input int unsigned hi);
      return byte_type'($urandom_range(lo, hi));
   endfunction

   function automatic byte_type rand_cont();
      return rand_byte(8'h80, 8'hbf);
   endfunction

   function automatic byte_type rand_lead(input int n);
      case (n)
         2: return rand_byte(u8vsd_pkg::LEAD2_MIN, u8vsd_pkg::LEAD2_MAX);
         3: return rand_byte(u8vsd_pkg::LEAD3_MIN, u8vsd_pkg::LEAD3_MAX);
         default: return rand_byte(u8vsd_pkg::LEAD4_MIN, u8vsd_pkg::LEAD4_MAX);
      endcase
   endfunction

   // request driver: predicts on acceptance, then offers the next beat
   always @(posedge clock) begin
      stream_beat_type next_beat;
      int              pct;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predicted_q.push_back(decode_beat(u8vsd_pkg::op_type'(req_op), req_byte_in));
            beats_sent++;
         end
         pct = (beats_sent * 3 < stream_len) ? 7 :
               (beats_sent * 3 < 2 * stream_len) ? 50 : 0;
         if (!req_valid || req_ready) begin
            if (byte_stream_q.size() != 0 && $urandom_range(0, 99) >= pct) begin
               next_beat = byte_stream_q.pop_front();
               req_valid   <= 1'b1;
               req_op      <= next_beat.op;
               req_byte_in <= next_beat.data;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // one long receiver hold-off early in the last phase, so the block fills up
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
         end else if (!hold_done && beats_checked >= 2 * stream_len / 3 + 20) begin
            hold_done <= 1'b1;
            hold_left <= 300;
         end
      end
   end

   // result monitor and receiver back-pressure
   always @(posedge clock) begin
      u8vsd_pkg::result_type want;
      int                    pct;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_q.size() == 0) begin
               $error("result beat with nothing predicted: kind %0d, code point %h",
                      rsp_kind, rsp_code_point);
               mismatch_count++;
            end else begin
               want = predicted_q.pop_front();
               if (rsp_kind !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
                  mismatch_count++;
               end
               if (rsp_code_point !== want.code_point) begin
                  $error("code_point: expected %h, got %h", want.code_point, rsp_code_point);
                  mismatch_count++;
               end
               if (rsp_error_code !== want.error_code) begin
                  $error("error_code: expected %0d, got %0d", want.error_code, rsp_error_code);
                  mismatch_count++;
               end
               if (rsp_pending_count !== want.pending_count) begin
                  $error("pending_count: expected %0d, got %0d",
                         want.pending_count, rsp_pending_count);
                  mismatch_count++;
               end
            end
            beats_checked++;
         end
         pct = (beats_checked * 3 < stream_len) ? 50 :
               (beats_checked * 3 < 2 * stream_len) ? 7 : 0;
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= pct);
         end
      end
   end

   // stimulus build, reset and end of run
   initial begin
      cp_type cp;
      int     n;
      int     k;
      int     pick;

      // directed opening: BOM, length boundaries, line ends
      put_char(u8vsd_pkg::CP_BOM);
      put_char(21'h000000);
      put_char(21'h00007f);
      put_char(21'h000080);
      put_char(21'h000800);
      put_char(21'h00d7ff);
      put_char(21'h010000);
      put_char(21'h10ffff);
      put_char(u8vsd_pkg::CP_CR);
      put_char(u8vsd_pkg::CP_LF);
      put_char(u8vsd_pkg::CP_LF);
      put_char(u8vsd_pkg::CP_CR);

      // random well-formed characters
      while (byte_stream_q.size() < 1050) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            cp = cp_type'($urandom_range(0, 127));
         end else if (pick < 38) begin
            cp = pick[0] ? u8vsd_pkg::CP_CR : u8vsd_pkg::CP_LF;
         end else if (pick < 58) begin
            cp = cp_type'($urandom_range(21'h80, 21'h7ff));
         end else if (pick < 80) begin
            do cp = cp_type'($urandom_range(21'h800, 21'hffff));
            while (cp >= 21'h00d800 && cp <= 21'h00dfff);
         end else if (pick < 95) begin
            cp = cp_type'($urandom_range(21'h010000, 21'h10ffff));
         end else begin
            cp = BOUNDARY_CPS[$urandom_range(0, 10)];
         end
         put_char(cp);
      end

      // one way of closing the stream
      case ($urandom_range(0, 4))
         0: begin
            close_reason = "a clean end of stream";
            push_beat(u8vsd_pkg::OP_END, '0);
         end
         1: begin
            close_reason = "a bad lead byte";
            push_beat(u8vsd_pkg::OP_DATA, $urandom_range(0, 1) ? rand_byte(8'h80, 8'hc1)
                                                               : rand_byte(8'hf5, 8'hff));
         end
         2: begin
            close_reason = "a bad continuation byte";
            n = $urandom_range(2, 4);
            k = $urandom_range(1, n - 1);
            push_beat(u8vsd_pkg::OP_DATA, rand_lead(n));
            for (int i = 1; i < n; i++) begin
               if (i == k) begin
                  push_beat(u8vsd_pkg::OP_DATA, $urandom_range(0, 1) ? rand_byte(8'h00, 8'h7f)
                                                                     : rand_byte(8'hc0, 8'hff));
               end else begin
                  push_beat(u8vsd_pkg::OP_DATA, rand_cont());
               end
            end
         end
         3: begin
            close_reason = "an overlong or surrogate form";
            case ($urandom_range(0, 3))
               0: begin
                  push_beat(u8vsd_pkg::OP_DATA, u8vsd_pkg::LEAD3_MIN);
                  push_beat(u8vsd_pkg::OP_DATA, rand_byte(8'h80, u8vsd_pkg::E0_SEC_MIN - 1));
                  push_beat(u8vsd_pkg::OP_DATA, rand_cont());
               end
               1: begin
                  push_beat(u8vsd_pkg::OP_DATA, u8vsd_pkg::LEAD_SURR);
                  push_beat(u8vsd_pkg::OP_DATA, rand_byte(u8vsd_pkg::ED_SEC_MAX + 1, 8'hbf));
                  push_beat(u8vsd_pkg::OP_DATA, rand_cont());
               end
               2: begin
                  push_beat(u8vsd_pkg::OP_DATA, u8vsd_pkg::LEAD4_MIN);
                  push_beat(u8vsd_pkg::OP_DATA, rand_byte(8'h80, u8vsd_pkg::F0_SEC_MIN - 1));
                  push_beat(u8vsd_pkg::OP_DATA, rand_cont());
                  push_beat(u8vsd_pkg::OP_DATA, rand_cont());
               end
               default: begin
                  push_beat(u8vsd_pkg::OP_DATA, u8vsd_pkg::LEAD4_MAX);
                  push_beat(u8vsd_pkg::OP_DATA, rand_byte(u8vsd_pkg::F4_SEC_MAX + 1, 8'hbf));
                  push_beat(u8vsd_pkg::OP_DATA, rand_cont());
                  push_beat(u8vsd_pkg::OP_DATA, rand_cont());
               end
            endcase
         end
         default: begin
            close_reason = "an end of stream inside a sequence";
            n = $urandom_range(2, 4);
            k = $urandom_range(1, n - 1);
            push_beat(u8vsd_pkg::OP_DATA, rand_lead(n));
            for (int i = 1; i < k; i++) push_beat(u8vsd_pkg::OP_DATA, rand_cont());
            push_beat(u8vsd_pkg::OP_END, '0);
         end
      endcase

      // noise into the sticky finished or failed state
      repeat (40) push_beat(u8vsd_pkg::op_type'($urandom_range(0, 3) == 0),
                            rand_byte(0, 255));
      stream_len = byte_stream_q.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (byte_stream_q.size() != 0 || req_valid || predicted_q.size() != 0);
      repeat (16) @(posedge clock);

      $display("%0d request beats sent, %0d result beats checked, %0d mismatches",
               beats_sent, beats_checked, mismatch_count);
      $display("well-formed text closed by %s, then traffic into the sticky state",
               close_reason);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

[files.f]
src/u8vsd_pkg.sv
src/u8vsd_decode.sv
src/utf8_validating_stream_decoder_core.sv
tb/utf8_validating_stream_decoder_core_test.sv
